[rtl/alr_pkg.sv]
// Shared types and constants for the antialiased line rasterizer.
package alr_pkg;

   // Fixed-point formats
   localparam int CoordW    = 16;              // endpoint coordinate, Q12.4
   localparam int CoordFrac = 4;
   localparam int GradFrac  = 16;
   localparam int GradW     = 18;              // gradient, signed Q1.16
   localparam int CrossW    = 30;              // minor crossing, signed Q.16
   localparam int ColW      = CoordW - CoordFrac + 1;  // major pixel column
   localparam int PosW      = ColW + 1;        // pixel position before wrap
   localparam int PixW      = 12;
   localparam int CovW      = 8;
   localparam int WinW      = 13;
   localparam int WeightW   = GradFrac + CoordFrac + 1;  // weight, unit 2^20
   localparam int DivW      = CoordW + 1;      // divider operand and quotient
   localparam int MulBW     = CoordFrac + 2;   // small multiplier operand
   localparam int MulPW     = GradW + MulBW;
   localparam int CsrAddrW  = 3;
   localparam int CsrDataW  = 32;

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [WinW-1:0] WIN_RESET = 13'd1024;

   typedef struct packed {
      logic               action;
      logic signed [15:0] x_start;
      logic signed [15:0] y_start;
      logic signed [15:0] x_end;
      logic signed [15:0] y_end;
   } req_type;

   typedef struct packed {
      logic signed [11:0] pix_x;
      logic signed [11:0] pix_y;
      logic [7:0]         coverage;
      logic               visible;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORDER,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_E0_MUL,
      ST_E0_SUM,
      ST_E0_GAP,
      ST_E0_EMIT,
      ST_E1_MUL,
      ST_E1_SUM,
      ST_E1_GAP,
      ST_E1_EMIT,
      ST_STEP_HI,
      ST_STEP_LO
   } state_type;

   typedef enum logic {
      MUL_DIST,
      MUL_GAP
   } mul_op_type;

   typedef enum logic [1:0] {
      EMIT_END0,
      EMIT_END1,
      EMIT_HI,
      EMIT_LO
   } emit_type;

   typedef struct packed {
      logic       req_ready;
      logic       order_en;
      logic       div_start;
      logic       grad_en;
      logic       mul_en;
      mul_op_type mul_op;
      logic       end_sel;
      logic       ye_en;
      logic       emit_en;
      emit_type   emit_kind;
   } ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic action;
      logic line_active;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

[rtl/antialiased_line_rasterizer.sv]
// Top level of the Wu antialiased line rasterizer.
//
//   Channel   Direction  Handshake              Content
//   req_*     in         req_valid / req_ready  action and two Q12.4 endpoints
//   rsp_*     out        rsp_valid / rsp_ready  one pixel: x, y, coverage, visible, last
//   APB       in/out     psel, penable, pready  window width (0x0), window height (0x4)
//
// From acceptance until req_ready returns, a start request passes through a state that swaps
// and orders the endpoints, the radix-2 divider that forms the gradient (load,
// 17 quotient bits, hand-off), and multiply, sum, gap and emit states per endpoint
// around the shared small multiplier.
// A step request emits two pixels after acceptance: the row at the crossing, then the one below.
// A step with no line loaded is dropped in its acceptance cycle.
// A stalled result channel holds the sequencer in its emit state; the output register
// lets the next request be accepted while the last pixel still waits.
// Synchronous reset returns to idle with no line loaded and a 1024 x 1024 window.
module antialiased_line_rasterizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  alr_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output alr_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [alr_pkg::CsrAddrW-1:0]   paddr,
   input  logic [alr_pkg::CsrDataW-1:0]   pwdata,
   output logic [alr_pkg::CsrDataW-1:0]   prdata,
   output logic                           pready
);

   localparam int CW  = alr_pkg::CoordW;
   localparam int GW  = alr_pkg::GradW;
   localparam int XW  = alr_pkg::CrossW;
   localparam int LW  = alr_pkg::ColW;
   localparam int PW  = alr_pkg::PosW;
   localparam int DW  = alr_pkg::DivW;
   localparam int BW  = alr_pkg::MulBW;
   localparam int MW  = alr_pkg::MulPW;
   localparam int CF  = alr_pkg::CoordFrac;
   localparam int GF  = alr_pkg::GradFrac;
   localparam int UpS = GF - CF;

   localparam logic signed [GW-1:0] GradOne  = GW'(1) << GF;
   localparam logic signed [CW:0]   HalfPix  = (CW + 1)'(1) << (CF - 1);
   localparam logic signed [BW-1:0] HalfB    = BW'(1) << (CF - 1);
   localparam logic [BW-1:0]        OneB     = BW'(1) << CF;
   localparam logic [GF:0]          OneG     = (GF + 1)'(1) << GF;

   alr_pkg::ctrl_type   ctrl;
   alr_pkg::status_type status;
   alr_pkg::rsp_type    pix;

   // ---------------------------------------------------------------- config
   logic [alr_pkg::WinW-1:0] win_w_ff, win_w_in;
   logic [alr_pkg::WinW-1:0] win_h_ff, win_h_in;
   logic                     csr_write;

   // Decode the register by its word address; the byte offset is ignored.
   always_comb begin
      csr_write = psel && penable && pwrite;
      win_w_in  = win_w_ff;
      win_h_in  = win_h_ff;
      if (csr_write && paddr[2] == alr_pkg::REG_WIDTH) begin
         win_w_in = pwdata[alr_pkg::WinW-1:0];
      end
      if (csr_write && paddr[2] == alr_pkg::REG_HEIGHT) begin
         win_h_in = pwdata[alr_pkg::WinW-1:0];
      end
      prdata = (paddr[2] == alr_pkg::REG_HEIGHT) ?
               alr_pkg::CsrDataW'(win_h_ff) : alr_pkg::CsrDataW'(win_w_ff);
      pready = 1'b1;
   end

   // ---------------------------------------------------------------- request capture
   alr_pkg::req_type in_ff, in_in;
   logic             req_fire;

   always_comb begin
      req_ready = ctrl.req_ready;
      req_fire  = req_valid && ctrl.req_ready;
      in_in     = req_fire ? req_data : in_ff;
   end

   // ---------------------------------------------------------------- setup: swap, order
   logic signed [CW-1:0] x0, y0, x1, y1;
   logic signed [CW:0]   dx_raw, dy_raw, dmin;
   logic [DW-1:0]        adx, ady, adm;
   logic                 steep;
   logic signed [CW-1:0] mj0, mn0, mj1, mn1;
   logic                 flip;

   logic                 steep_ff, steep_in;
   logic signed [CW-1:0] maj0_ff, maj0_in, min0_ff, min0_in;
   logic signed [CW-1:0] maj1_ff, maj1_in, min1_ff, min1_in;
   logic [DW-1:0]        dx_ff, dx_in, dyabs_ff, dyabs_in;
   logic                 dyneg_ff, dyneg_in;

   always_comb begin
      x0     = $signed(in_ff.x_start);
      y0     = $signed(in_ff.y_start);
      x1     = $signed(in_ff.x_end);
      y1     = $signed(in_ff.y_end);
      dx_raw = $signed({x1[CW-1], x1}) - $signed({x0[CW-1], x0});
      dy_raw = $signed({y1[CW-1], y1}) - $signed({y0[CW-1], y0});
      adx    = dx_raw[CW] ? DW'(-dx_raw) : DW'(dx_raw);
      ady    = dy_raw[CW] ? DW'(-dy_raw) : DW'(dy_raw);
      steep  = ady > adx;
      mj0    = steep ? y0 : x0;
      mn0    = steep ? x0 : y0;
      mj1    = steep ? y1 : x1;
      mn1    = steep ? x1 : y1;
      // order by major coordinate; equal endpoints keep their order
      flip   = mj0 > mj1;
      maj0_in = maj0_ff;
      min0_in = min0_ff;
      maj1_in = maj1_ff;
      min1_in = min1_ff;
      steep_in = steep_ff;
      dx_in    = dx_ff;
      dyabs_in = dyabs_ff;
      dyneg_in = dyneg_ff;
      dmin     = flip ? ($signed({mn0[CW-1], mn0}) - $signed({mn1[CW-1], mn1})) :
                        ($signed({mn1[CW-1], mn1}) - $signed({mn0[CW-1], mn0}));
      adm      = dmin[CW] ? DW'(-dmin) : DW'(dmin);
      if (ctrl.order_en) begin
         steep_in = steep;
         maj0_in  = flip ? mj1 : mj0;
         min0_in  = flip ? mn1 : mn0;
         maj1_in  = flip ? mj0 : mj1;
         min1_in  = flip ? mn0 : mn1;
         dx_in    = steep ? ady : adx;
         dyabs_in = adm;
         dyneg_in = dmin[CW];
      end
   end

   // ---------------------------------------------------------------- gradient divide
   logic                 div_done;
   logic [DW-1:0]        div_quot;
   logic signed [GW-1:0] grad_ff, grad_in;

   alr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .num   (dyabs_ff),
      .den   (dx_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // A zero-length major span has zero minor span too: use a gradient of one.
   always_comb begin
      grad_in = grad_ff;
      if (ctrl.grad_en) begin
         if (dx_ff == '0) begin
            grad_in = GradOne;
         end else if (dyneg_ff) begin
            grad_in = -$signed({1'b0, div_quot});
         end else begin
            grad_in = $signed({1'b0, div_quot});
         end
      end
   end

   // ---------------------------------------------------------------- endpoints
   logic signed [CW:0]    sum0, sum1;
   logic signed [LW-1:0]  col0, col1;
   logic [CF-1:0]         frac0, frac1, frac_sel;
   logic signed [CW-1:0]  minor_sel;
   logic signed [BW-1:0]  col_off;
   logic [BW-1:0]         gap;
   logic                  single;

   always_comb begin
      // column = floor(x + 0.5); the fraction of x + 0.5 sets the end gap
      sum0      = $signed({maj0_ff[CW-1], maj0_ff}) + HalfPix;
      sum1      = $signed({maj1_ff[CW-1], maj1_ff}) + HalfPix;
      col0      = sum0[CW:CF];
      col1      = sum1[CW:CF];
      frac0     = sum0[CF-1:0];
      frac1     = sum1[CF-1:0];
      frac_sel  = ctrl.end_sel ? frac1 : frac0;
      minor_sel = ctrl.end_sel ? min1_ff : min0_ff;
      col_off   = HalfB - $signed(BW'(frac_sel));
      gap       = ctrl.end_sel ? BW'(frac1) : (OneB - BW'(frac0));
      single    = $signed({col1[LW-1], col1}) <= ($signed({col0[LW-1], col0}) + PW'(1));
   end

   // ---------------------------------------------------------------- shared multiplier
   logic signed [GW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [MW-1:0] mul_ff, mul_in;
   logic signed [XW-1:0] ye_ff, ye_in;

   always_comb begin
      case (ctrl.mul_op)
         alr_pkg::MUL_DIST: begin
            mul_a = grad_ff;
            mul_b = col_off;
         end
         alr_pkg::MUL_GAP: begin
            mul_a = $signed({1'b0, OneG - {1'b0, ye_ff[GF-1:0]}});
            mul_b = $signed(gap);
         end
         default: begin
            mul_a = grad_ff;
            mul_b = col_off;
         end
      endcase
      mul_in = ctrl.mul_en ? (mul_a * mul_b) : mul_ff;
      // crossing = y * 2^12 + floor(gradient * (column - x) / 16)
      ye_in = ye_ff;
      if (ctrl.ye_en) begin
         ye_in = $signed({{(XW - CW - UpS){minor_sel[CW-1]}}, minor_sel, {UpS{1'b0}}}) +
                 $signed({{(XW - MW + CF){mul_ff[MW-1]}}, mul_ff[MW-1:CF]});
      end
   end

   // ---------------------------------------------------------------- line walk state
   logic signed [XW-1:0] cross_ff, cross_in;
   logic signed [LW-1:0] cur_ff, cur_in;
   logic signed [LW-1:0] final_ff, final_in;
   logic                 active_ff, active_in;
   logic                 step_last;
   logic signed [PW-1:0] ip;

   always_comb begin
      ip        = cross_ff[XW-1:GF];
      step_last = ($signed({cur_ff[LW-1], cur_ff}) + PW'(1)) >=
                  $signed({final_ff[LW-1], final_ff});
      cross_in  = cross_ff;
      cur_in    = cur_ff;
      final_in  = final_ff;
      active_in = active_ff;
      if (ctrl.emit_en) begin
         case (ctrl.emit_kind)
            alr_pkg::EMIT_END0: begin
               cross_in = ye_ff + $signed({{(XW - GW){grad_ff[GW-1]}}, grad_ff});
               cur_in   = col0 + LW'(1);
            end
            alr_pkg::EMIT_END1: begin
               final_in  = col1;
               active_in = !single;
            end
            alr_pkg::EMIT_LO: begin
               cross_in = cross_ff + $signed({{(XW - GW){grad_ff[GW-1]}}, grad_ff});
               cur_in   = cur_ff + LW'(1);
               if (step_last) begin
                  active_in = 1'b0;
               end
            end
            default: begin
               cross_in = cross_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- pixel select
   logic signed [PW-1:0]            px_major, px_minor;
   logic [alr_pkg::WeightW-1:0]     px_weight;
   logic                            px_last;

   always_comb begin
      case (ctrl.emit_kind)
         alr_pkg::EMIT_END0: begin
            px_major  = $signed({col0[LW-1], col0});
            px_minor  = ye_ff[XW-1:GF];
            px_weight = mul_ff[alr_pkg::WeightW-1:0];
            px_last   = 1'b0;
         end
         alr_pkg::EMIT_END1: begin
            px_major  = $signed({col1[LW-1], col1});
            px_minor  = ye_ff[XW-1:GF];
            px_weight = mul_ff[alr_pkg::WeightW-1:0];
            px_last   = single;
         end
         alr_pkg::EMIT_HI: begin
            px_major  = $signed({cur_ff[LW-1], cur_ff});
            px_minor  = ip;
            px_weight = {OneG - {1'b0, cross_ff[GF-1:0]}, {CF{1'b0}}};
            px_last   = 1'b0;
         end
         alr_pkg::EMIT_LO: begin
            px_major  = $signed({cur_ff[LW-1], cur_ff});
            px_minor  = ip + PW'(1);
            px_weight = {1'b0, cross_ff[GF-1:0], {CF{1'b0}}};
            px_last   = step_last;
         end
         default: begin
            px_major  = '0;
            px_minor  = '0;
            px_weight = '0;
            px_last   = 1'b0;
         end
      endcase
   end

   alr_pixel u_pixel (
      .steep  (steep_ff),
      .major  (px_major),
      .minor  (px_minor),
      .weight (px_weight),
      .last   (px_last),
      .win_w  (win_w_ff),
      .win_h  (win_h_ff),
      .pix    (pix)
   );

   // ---------------------------------------------------------------- output register
   logic             rsp_valid_ff, rsp_valid_in;
   alr_pkg::rsp_type rsp_ff, rsp_in;
   logic             out_free;

   // Take a new pixel when the register is empty or drains this cycle.
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = ctrl.emit_en ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = ctrl.emit_en ? pix : rsp_ff;
      rsp_valid    = rsp_valid_ff;
      rsp_data     = rsp_ff;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      status.req_fire    = req_fire;
      status.action      = req_data.action;
      status.line_active = active_ff;
      status.div_done    = div_done;
      status.out_free    = out_free;
   end

   alr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_w_ff     <= alr_pkg::WIN_RESET;
         win_h_ff     <= alr_pkg::WIN_RESET;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         steep_ff     <= 1'b0;
         grad_ff      <= '0;
         cross_ff     <= '0;
         cur_ff       <= '0;
         final_ff     <= '0;
      end else begin
         win_w_ff     <= win_w_in;
         win_h_ff     <= win_h_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         steep_ff     <= steep_in;
         grad_ff      <= grad_in;
         cross_ff     <= cross_in;
         cur_ff       <= cur_in;
         final_ff     <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff    <= in_in;
      maj0_ff  <= maj0_in;
      min0_ff  <= min0_in;
      maj1_ff  <= maj1_in;
      min1_ff  <= min1_in;
      dx_ff    <= dx_in;
      dyabs_ff <= dyabs_in;
      dyneg_ff <= dyneg_in;
      mul_ff   <= mul_in;
      ye_ff    <= ye_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[rtl/alr_div.sv]
// Iterative restoring divider for the line gradient, one quotient bit per cycle.
module alr_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [alr_pkg::DivW-1:0] num,
   input  logic [alr_pkg::DivW-1:0] den,
   output logic                     done,
   output logic [alr_pkg::DivW-1:0] quot
);

   localparam int CntW = $clog2(alr_pkg::DivW);
   localparam logic [CntW-1:0] CntLast = CntW'(alr_pkg::DivW - 1);

   logic [alr_pkg::DivW:0]   rem_ff, rem_in;
   logic [alr_pkg::DivW-1:0] quo_ff, quo_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [alr_pkg::DivW:0]   trial;
   logic [alr_pkg::DivW:0]   diff;
   logic                     fits;

   // First step compares without a shift: numerator never exceeds the divisor.
   always_comb begin
      trial = (cnt_ff == '0) ? rem_ff : {rem_ff[alr_pkg::DivW-1:0], 1'b0};
      diff  = trial - {1'b0, den};
      fits  = (trial >= {1'b0, den});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff : trial;
         quo_in = {quo_ff[alr_pkg::DivW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/alr_pixel.sv]
// Pixel formatter: axis unswap, window clipping, coverage scaling.
module alr_pixel (
   input  logic                               steep,
   input  logic signed [alr_pkg::PosW-1:0]    major,
   input  logic signed [alr_pkg::PosW-1:0]    minor,
   input  logic [alr_pkg::WeightW-1:0]        weight,
   input  logic                               last,
   input  logic [alr_pkg::WinW-1:0]           win_w,
   input  logic [alr_pkg::WinW-1:0]           win_h,
   output alr_pkg::rsp_type                   pix
);

   localparam int ScaleW = alr_pkg::WeightW + alr_pkg::CovW;
   localparam int FracW  = alr_pkg::WeightW - 1;

   logic signed [alr_pkg::PosW-1:0] px;
   logic signed [alr_pkg::PosW-1:0] py;
   logic                            vis;
   logic [ScaleW-1:0]               scaled;

   always_comb begin
      px  = steep ? minor : major;
      py  = steep ? major : minor;
      vis = !px[alr_pkg::PosW-1] && !py[alr_pkg::PosW-1] &&
            (px < $signed({1'b0, win_w})) && (py < $signed({1'b0, win_h}));
      // w * 255 + half, then drop the fraction
      scaled = {weight, {alr_pkg::CovW{1'b0}}} - {{alr_pkg::CovW{1'b0}}, weight} +
               (ScaleW'(1) << (FracW - 1));
      pix.pix_x    = px[alr_pkg::PixW-1:0];
      pix.pix_y    = py[alr_pkg::PixW-1:0];
      pix.coverage = scaled[FracW +: alr_pkg::CovW];
      pix.visible  = vis;
      pix.last     = last;
   end

endmodule

[rtl/alr_ctrl.sv]
// Sequencer for the rasterizer: setup, divide, endpoint and step phases.
module alr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  alr_pkg::status_type  status,
   output alr_pkg::ctrl_type    ctrl
);

   alr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alr_pkg::ST_IDLE: begin
            if (status.req_fire) begin
               if (status.action == alr_pkg::ACT_START) begin
                  state_in = alr_pkg::ST_ORDER;
               end else if (status.line_active) begin
                  state_in = alr_pkg::ST_STEP_HI;
               end
            end
         end
         alr_pkg::ST_ORDER:    state_in = alr_pkg::ST_DIV_LOAD;
         alr_pkg::ST_DIV_LOAD: state_in = alr_pkg::ST_DIV_RUN;
         alr_pkg::ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = alr_pkg::ST_E0_MUL;
            end
         end
         alr_pkg::ST_E0_MUL: state_in = alr_pkg::ST_E0_SUM;
         alr_pkg::ST_E0_SUM: state_in = alr_pkg::ST_E0_GAP;
         alr_pkg::ST_E0_GAP: state_in = alr_pkg::ST_E0_EMIT;
         alr_pkg::ST_E0_EMIT: begin
            if (status.out_free) begin
               state_in = alr_pkg::ST_E1_MUL;
            end
         end
         alr_pkg::ST_E1_MUL: state_in = alr_pkg::ST_E1_SUM;
         alr_pkg::ST_E1_SUM: state_in = alr_pkg::ST_E1_GAP;
         alr_pkg::ST_E1_GAP: state_in = alr_pkg::ST_E1_EMIT;
         alr_pkg::ST_E1_EMIT: begin
            if (status.out_free) begin
               state_in = alr_pkg::ST_IDLE;
            end
         end
         alr_pkg::ST_STEP_HI: begin
            if (status.out_free) begin
               state_in = alr_pkg::ST_STEP_LO;
            end
         end
         alr_pkg::ST_STEP_LO: begin
            if (status.out_free) begin
               state_in = alr_pkg::ST_IDLE;
            end
         end
         default: state_in = alr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.mul_op    = alr_pkg::MUL_DIST;
      ctrl.emit_kind = alr_pkg::EMIT_END0;
      case (state_ff)
         alr_pkg::ST_IDLE:     ctrl.req_ready = 1'b1;
         alr_pkg::ST_ORDER:    ctrl.order_en  = 1'b1;
         alr_pkg::ST_DIV_LOAD: ctrl.div_start = 1'b1;
         alr_pkg::ST_DIV_RUN:  ctrl.grad_en   = status.div_done;
         alr_pkg::ST_E0_MUL: begin
            ctrl.mul_en = 1'b1;
         end
         alr_pkg::ST_E0_SUM: begin
            ctrl.ye_en = 1'b1;
         end
         alr_pkg::ST_E0_GAP: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_op = alr_pkg::MUL_GAP;
         end
         alr_pkg::ST_E0_EMIT: begin
            ctrl.emit_en   = status.out_free;
            ctrl.emit_kind = alr_pkg::EMIT_END0;
         end
         alr_pkg::ST_E1_MUL: begin
            ctrl.mul_en  = 1'b1;
            ctrl.end_sel = 1'b1;
         end
         alr_pkg::ST_E1_SUM: begin
            ctrl.ye_en   = 1'b1;
            ctrl.end_sel = 1'b1;
         end
         alr_pkg::ST_E1_GAP: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_op  = alr_pkg::MUL_GAP;
            ctrl.end_sel = 1'b1;
         end
         alr_pkg::ST_E1_EMIT: begin
            ctrl.emit_en   = status.out_free;
            ctrl.emit_kind = alr_pkg::EMIT_END1;
            ctrl.end_sel   = 1'b1;
         end
         alr_pkg::ST_STEP_HI: begin
            ctrl.emit_en   = status.out_free;
            ctrl.emit_kind = alr_pkg::EMIT_HI;
         end
         alr_pkg::ST_STEP_LO: begin
            ctrl.emit_en   = status.out_free;
            ctrl.emit_kind = alr_pkg::EMIT_LO;
         end
         default: ctrl.req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[dv/antialiased_line_rasterizer_tb.sv]
// Self-checking testbench for the line rasterizer: random lines against a pixel predictor.
`timescale 1ns / 1ps

module antialiased_line_rasterizer_tb;

   // Fixed-point units of the endpoint and crossing formats
   localparam longint CoordOne  = longint'(1) << alr_pkg::CoordFrac;
   localparam longint CoordHalf = CoordOne >> 1;
   localparam longint GradOne   = longint'(1) << alr_pkg::GradFrac;
   localparam longint CoordMin  = -(longint'(1) << (alr_pkg::CoordW - 1));
   localparam longint CoordMax  = (longint'(1) << (alr_pkg::CoordW - 1)) - 1;
   localparam longint CovMax    = (longint'(1) << alr_pkg::CovW) - 1;

   // Leave margin for a start request to finish before touching the registers
   localparam int SettleCycles = 40;
   localparam int PhaseItems   = 110;
   localparam int NumPhases    = 7;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   alr_pkg::req_type             req_data  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   alr_pkg::rsp_type             rsp_data;
   logic                         psel      = 1'b0;
   logic                         penable   = 1'b0;
   logic                         pwrite    = 1'b0;
   logic [alr_pkg::CsrAddrW-1:0] paddr     = '0;
   logic [alr_pkg::CsrDataW-1:0] pwdata    = '0;
   logic [alr_pkg::CsrDataW-1:0] prdata;
   logic                         pready;

   antialiased_line_rasterizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Requests waiting for the driver, and pixels the block still owes us
   alr_pkg::req_type pending_requests[$];
   alr_pkg::rsp_type expected_pixels[$];
   int               err_count = 0;

   // Shadow of the line walker: what the block should hold after each request
   bit     ln_steep    = 1'b0;
   bit     ln_active   = 1'b0;
   longint ln_grad     = 0;
   longint ln_cross    = 0;
   longint ln_col      = 0;
   longint ln_last_col = 0;
   longint win_width   = alr_pkg::WIN_RESET;
   longint win_height  = alr_pkg::WIN_RESET;

   // -------------------------------------------------------------------------
   // Line geometry shared by the predictor and the stimulus generator
   // -------------------------------------------------------------------------

   // Swap axes for steep lines (|dy| > |dx|), then order by the major axis.
   // a is the major coordinate, b the minor one, both still in Q12.4.
   function automatic void orient(input alr_pkg::req_type r, output bit steep,
                                  output longint a0, b0, a1, b1);
      longint x0, y0, x1, y1, t;
      x0 = r.x_start;
      y0 = r.y_start;
      x1 = r.x_end;
      y1 = r.y_end;
      steep = ((y1 >= y0) ? y1 - y0 : y0 - y1) > ((x1 >= x0) ? x1 - x0 : x0 - x1);
      if (steep) begin
         a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
         a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      if (a0 > a1) begin
         t = a0; a0 = a1; a1 = t;
         t = b0; b0 = b1; b1 = t;
      end
   endfunction

   // Pixel column of an endpoint: round half up, floor for negatives
   function automatic longint major_col(input longint a);
      return (a + CoordHalf) >>> alr_pkg::CoordFrac;
   endfunction

   // Scale a weight with unit 2^fb to the 0..255 coverage range, rounded
   function automatic longint weight_cov(input longint w, input int fb);
      longint r;
      r = (w * CovMax + ((longint'(1) << fb) >>> 1)) >>> fb;
      return (r > CovMax) ? CovMax : r;
   endfunction

   // Undo the axis swap, decide visibility on the full value, then wrap
   function automatic void push_pixel(input longint major, minor, cov, input bit last);
      alr_pkg::rsp_type p;
      longint           px, py;
      px = ln_steep ? minor : major;
      py = ln_steep ? major : minor;
      p.pix_x    = px[alr_pkg::PixW-1:0];
      p.pix_y    = py[alr_pkg::PixW-1:0];
      p.coverage = cov[alr_pkg::CovW-1:0];
      p.visible  = px >= 0 && py >= 0 && px < win_width && py < win_height;
      p.last     = last;
      expected_pixels.push_back(p);
   endfunction

   // Work out the pixels one accepted request causes and queue them
   function automatic void predict_pixels(input alr_pkg::req_type r);
      longint a0, b0, a1, b1, c0, c1, y0, y1, g0, g1, row;
      bit     done;
      if (r.action == alr_pkg::ACT_START) begin
         orient(r, ln_steep, a0, b0, a1, b1);
         // Gradient in Q.16, truncated toward zero; a point gets slope 1.0
         ln_grad = (a1 == a0) ? GradOne : ((b1 - b0) * GradOne) / (a1 - a0);
         c0 = major_col(a0);
         c1 = major_col(a1);
         // Minor crossing at each endpoint column, Q.16
         y0 = b0 * (GradOne / CoordOne) +
              ((ln_grad * (c0 * CoordOne - a0)) >>> alr_pkg::CoordFrac);
         y1 = b1 * (GradOne / CoordOne) +
              ((ln_grad * (c1 * CoordOne - a1)) >>> alr_pkg::CoordFrac);
         // Endpoint gaps: how much of the end column the line covers
         g0 = CoordOne - ((a0 + CoordHalf) & (CoordOne - 1));
         g1 = (a1 + CoordHalf) & (CoordOne - 1);
         done = c1 <= c0 + 1;
         push_pixel(c0, y0 >>> alr_pkg::GradFrac,
                    weight_cov((GradOne - (y0 & (GradOne - 1))) * g0,
                               alr_pkg::GradFrac + alr_pkg::CoordFrac),
                    1'b0);
         push_pixel(c1, y1 >>> alr_pkg::GradFrac,
                    weight_cov((GradOne - (y1 & (GradOne - 1))) * g1,
                               alr_pkg::GradFrac + alr_pkg::CoordFrac),
                    done);
         ln_cross    = y0 + ln_grad;
         ln_col      = c0 + 1;
         ln_last_col = c1;
         ln_active   = !done;
      end else if (ln_active) begin
         // Interior column: the row at the crossing gets 1 - frac, the one below frac
         row  = ln_cross >>> alr_pkg::GradFrac;
         g0   = ln_cross & (GradOne - 1);
         done = ln_col + 1 >= ln_last_col;
         push_pixel(ln_col, row, weight_cov(GradOne - g0, alr_pkg::GradFrac), 1'b0);
         push_pixel(ln_col, row + 1, weight_cov(g0, alr_pkg::GradFrac), done);
         ln_cross += ln_grad;
         ln_col++;
         if (done) ln_active = 1'b0;
      end
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   // Number of step requests that walk a line from its start to its last pixel
   function automatic int interior_steps(input alr_pkg::req_type r);
      bit     s;
      longint a0, b0, a1, b1, n;
      orient(r, s, a0, b0, a1, b1);
      n = major_col(a1) - major_col(a0) - 1;
      return (n > 0) ? int'(n) : 0;
   endfunction

   // Queue one request with random endpoint bits; a step ignores them
   function automatic void push_random(input logic act);
      alr_pkg::req_type r;
      r.action = act;
      {r.x_start, r.y_start} = $urandom;
      {r.x_end, r.y_end} = $urandom;
      pending_requests.push_back(r);
   endfunction

   // Queue a start and the steps that follow it; cap < 0 walks the whole line,
   // otherwise stop after cap steps so the next start abandons it
   function automatic int add_start(input longint xs, ys, xe, ye, input int cap);
      alr_pkg::req_type r;
      int               n;
      r.action  = alr_pkg::ACT_START;
      r.x_start = xs[alr_pkg::CoordW-1:0];
      r.y_start = ys[alr_pkg::CoordW-1:0];
      r.x_end   = xe[alr_pkg::CoordW-1:0];
      r.y_end   = ye[alr_pkg::CoordW-1:0];
      pending_requests.push_back(r);
      n = interior_steps(r);
      if (cap >= 0 && cap < n) n = cap;
      repeat (n) push_random(alr_pkg::ACT_STEP);
      return n + 1;
   endfunction

   // Second endpoint at +/- delta from the anchor, mirrored back into range
   function automatic longint place(input longint anchor, delta);
      longint e;
      e = ($urandom_range(0, 1) != 0) ? anchor + delta : anchor - delta;
      if (e > CoordMax || e < CoordMin) e = 2 * anchor - e;
      return e;
   endfunction

   // One random line: mostly short ones near the window, a few long or far away;
   // budget is how many requests the phase still has room for
   function automatic int add_line(input int budget);
      longint span, dmaj, dmin, ax, ay, bx, by;
      int     pick, cap, pushed;
      pick = $urandom_range(0, 19);
      span = (pick < 16) ? 8 * CoordOne : (pick < 19) ? 40 * CoordOne : 300 * CoordOne;
      dmaj = $urandom_range(0, span);
      dmin = $urandom_range(0, dmaj);
      if ($urandom_range(0, 7) == 0) begin
         ax = longint'($urandom_range(0, 65535)) + CoordMin;
         ay = longint'($urandom_range(0, 65535)) + CoordMin;
      end else begin
         ax = longint'($urandom_range(0, 1300 * CoordOne)) - 100 * CoordOne;
         ay = longint'($urandom_range(0, 1300 * CoordOne)) - 100 * CoordOne;
      end
      if ($urandom_range(0, 1) != 0) begin
         bx = place(ax, dmaj);
         by = place(ay, dmin);
      end else begin
         bx = place(ax, dmin);
         by = place(ay, dmaj);
      end
      // Mostly walk to the end; now and then cut the line short or overrun it.
      // Never walk past what is left of the phase.
      pick   = $urandom_range(0, 9);
      cap    = (pick == 0) ? $urandom_range(0, 3) : -1;
      if (cap < 0 || cap > budget - 1) cap = budget - 1;
      pushed = add_start(ax, ay, bx, by, cap);
      if (pick == 1) begin
         push_random(alr_pkg::ACT_STEP);   // line may be done: then dropped
         pushed++;
      end
      return pushed;
   endfunction

   task automatic random_phase(input int target);
      int count;
      count = 0;
      while (count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            // Noise: a fully random start or a stray step
            push_random($urandom_range(0, 1) ? alr_pkg::ACT_STEP : alr_pkg::ACT_START);
            count++;
         end else begin
            count += add_line(target - count);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Register access (APB setup and access phases, pready always high)
   // -------------------------------------------------------------------------

   function automatic logic [alr_pkg::CsrAddrW-1:0] csr_addr(input logic idx);
      return alr_pkg::CsrAddrW'(idx) << 2;
   endfunction

   task automatic csr_write(input logic idx, input logic [alr_pkg::WinW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= csr_addr(idx);
      pwdata  <= alr_pkg::CsrDataW'(value);
      @(posedge clock);
      penable <= 1'b1;
      // the register takes the value at this edge
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == alr_pkg::REG_WIDTH) win_width = value;
      else win_height = value;
   endtask

   task automatic csr_read(input logic idx, output logic [alr_pkg::CsrDataW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= csr_addr(idx);
      @(posedge clock);
      penable <= 1'b1;
      // sample mid access cycle, clear of the edge
      @(negedge clock);
      value = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Block until every queued request is in and every pixel is out, then settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: predict at acceptance, then hold off for a random req_gap per
   // request; every 64 requests, maybe switch to back-to-back bursts
   // -------------------------------------------------------------------------
   int req_gap   = 0;
   int req_count = 0;
   bit req_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_pixels(req_data);
            req_count++;
            if (req_count % 64 == 0) req_burst = ($urandom_range(0, 2) == 0);
            req_gap = req_burst ? 0 : $urandom_range(0, 5);
         end
         // Hold valid and payload until accepted; only then advance
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Pixel monitor: check each accepted pixel against the oldest prediction,
   // then stall ready for a random rsp_stall, with burst stretches of no stall
   // -------------------------------------------------------------------------
   int rsp_stall = 0;
   int rsp_count = 0;
   bit rsp_burst = 1'b0;

   always @(posedge clock) begin
      alr_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               err_count++;
               $display("%0t: expected no pixel, got x=%0d y=%0d cov=%0d vis=%0b last=%0b",
                        $time, rsp_data.pix_x, rsp_data.pix_y, rsp_data.coverage,
                        rsp_data.visible, rsp_data.last);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.pix_x !== want.pix_x || rsp_data.pix_y !== want.pix_y ||
                   rsp_data.coverage !== want.coverage ||
                   rsp_data.visible !== want.visible || rsp_data.last !== want.last) begin
                  err_count++;
                  $display({"%0t: pixel mismatch: expected x=%0d y=%0d cov=%0d vis=%0b ",
                            "last=%0b, got x=%0d y=%0d cov=%0d vis=%0b last=%0b"},
                           $time, want.pix_x, want.pix_y, want.coverage, want.visible,
                           want.last, rsp_data.pix_x, rsp_data.pix_y, rsp_data.coverage,
                           rsp_data.visible, rsp_data.last);
               end
            end
            rsp_count++;
            if (rsp_count % 64 == 0) rsp_burst = ($urandom_range(0, 2) == 0);
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 5);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [alr_pkg::WinW-1:0]     w, h;
      logic [alr_pkg::CsrDataW-1:0] rd;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lines on the reset window of 1024 x 1024
      push_random(alr_pkg::ACT_STEP);                             // no line: dropped
      void'(add_start(0, 0, 0, 0, -1));                           // same pixel twice
      void'(add_start(CoordMin, CoordMax, CoordMax, CoordMin, 2)); // extremes, wrapped
      void'(add_start(CoordMin, CoordMin, CoordMin + 48, CoordMax, 1)); // steep extreme
      void'(add_start(163, 325, 200, 329, -1));                   // shallow, fractional
      void'(add_start(807, 642, 796, 585, -1));                   // steep, reversed
      void'(add_start(32, 32, 80, 80, -1));                       // exact diagonal
      void'(add_start(80, 144, 99, 148, -1));                     // adjacent end columns
      push_random(alr_pkg::ACT_STEP);                             // after last: dropped
      void'(add_start(-53, -32, 17, 25, -1));                     // left of and above window
      void'(add_start(0, 160, 480, 192, 1));                      // abandoned by next start
      void'(add_start(16352, 16376, 16400, 16376, -1));           // across bottom-right edge
      void'(add_start(1600, 1600, 1600, 1664, 0));                // vertical
      random_phase(PhaseItems);
      wait_idle();

      // Sweep the window through its extremes; registers change only when idle
      for (int ph = 0; ph < NumPhases; ph++) begin
         case (ph)
            0: begin w = '0;                h = alr_pkg::WIN_RESET; end  // nothing visible
            1: begin w = alr_pkg::WIN_RESET; h = '0;               end
            2: begin w = 13'd1;             h = 13'd1;             end
            3: begin w = 13'd4096;          h = 13'd4096;          end
            4: begin w = '1;                h = '1;                end
            5: begin
               w = alr_pkg::WinW'($urandom_range(1, 4096));
               h = alr_pkg::WinW'($urandom_range(1, 4096));
            end
            default: begin w = alr_pkg::WIN_RESET; h = alr_pkg::WIN_RESET; end
         endcase
         csr_write(alr_pkg::REG_WIDTH, w);
         csr_write(alr_pkg::REG_HEIGHT, h);
         csr_read(alr_pkg::REG_WIDTH, rd);
         if (rd[alr_pkg::WinW-1:0] !== w) begin
            err_count++;
            $display("%0t: window width readback: expected %0d, got %0d", $time, w,
                     rd[alr_pkg::WinW-1:0]);
         end
         csr_read(alr_pkg::REG_HEIGHT, rd);
         if (rd[alr_pkg::WinW-1:0] !== h) begin
            err_count++;
            $display("%0t: window height readback: expected %0d, got %0d", $time, h,
                     rd[alr_pkg::WinW-1:0]);
         end
         @(negedge clock);
         random_phase(PhaseItems);
         wait_idle();
      end

      if (err_count == 0 && expected_pixels.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #(10_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
